[sv/psar_pkg.sv]
`timescale 1ns / 1ps

package psar_pkg;

    localparam int OP_W      = 4;
    localparam int DATA_W    = 8;
    localparam int ADDR_W    = 15;
    localparam int FINE_X_W  = 3;
    localparam int FETCH_W   = 14;
    localparam int SHIFT_W   = 3;

    // operation codes
    localparam logic [OP_W-1:0] OP_CTRL_WRITE   = 4'd0;
    localparam logic [OP_W-1:0] OP_SCROLL_WRITE = 4'd1;
    localparam logic [OP_W-1:0] OP_ADDR_WRITE   = 4'd2;
    localparam logic [OP_W-1:0] OP_STATUS_READ  = 4'd3;
    localparam logic [OP_W-1:0] OP_DATA_ACCESS  = 4'd4;
    localparam logic [OP_W-1:0] OP_HINC         = 4'd5;
    localparam logic [OP_W-1:0] OP_VINC         = 4'd6;
    localparam logic [OP_W-1:0] OP_HTRANSFER    = 4'd7;
    localparam logic [OP_W-1:0] OP_VTRANSFER    = 4'd8;

    localparam logic [ADDR_W-1:0] HORIZ_MASK = 15'h041F;
    localparam logic [ADDR_W-1:0] VERT_MASK  = 15'h7BE0;
    localparam logic [4:0] COARSE_LAST   = 5'd31;
    localparam logic [4:0] COARSE_Y_WRAP = 5'd29;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;

    typedef logic [ADDR_W-1:0] addr_t;

    // coarse x step: 31 wraps to 0 and flips the horizontal nametable
    function automatic addr_t coarse_step_x(input addr_t a);
        addr_t r;
        r = a;
        if (a[4:0] == COARSE_LAST) begin
            r[4:0] = 5'd0;
            r[10]  = ~a[10];
        end else begin
            r[4:0] = a[4:0] + 5'd1;
        end
        return r;
    endfunction

    // fine y / coarse y step
    function automatic addr_t coarse_step_y(input addr_t a);
        addr_t r;
        r = a;
        if (a[14:12] != 3'd7) begin
            r[14:12] = a[14:12] + 3'd1;
        end else begin
            r[14:12] = 3'd0;
            if (a[9:5] == COARSE_Y_WRAP) begin
                r[9:5] = 5'd0;
                r[11]  = ~a[11];
            end else if (a[9:5] == COARSE_LAST) begin
                r[9:5] = 5'd0;
            end else begin
                r[9:5] = a[9:5] + 5'd1;
            end
        end
        return r;
    endfunction

endpackage

[sv/ppu_scroll_address_registers.sv]
`timescale 1ns / 1ps

// Scroll and address register unit of a tile video chip (the usual temporary
// address / current address / fine x / write toggle scheme). Each input
// transaction carries one operation: a cpu write to the control, scroll or
// address port, a status read, a data port access, or a rendering timing
// event (horizontal or vertical step, horizontal or vertical copy). The unit
// answers every input transaction with exactly one output transaction giving
// the current address after the update, fine x, the toggle, and the derived
// nametable and attribute fetch addresses and attribute shift. Throughput is
// one transaction per clock while the result side accepts. An accepted
// transaction is captured in the input register and then in the result
// register, which drives m_axis_tvalid (one input register, one result
// register). While the result side is held off, two transactions are held
// before s_axis_tready drops. The update is a single pass of combinational
// logic between those registers, and the state registers are written in the
// same cycle the result register is loaded.
module ppu_scroll_address_registers (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input transaction
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [3:0] op, [11:4] data, [12] rendering_enabled, [13] on_render_line
    input  logic [psar_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // result transaction
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [14:0] vram_addr, [17:15] fine_x, [18] write_toggle,
    // [32:19] nametable_fetch_addr, [46:33] attribute_fetch_addr,
    // [49:47] attribute_shift
    output logic [psar_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import psar_pkg::*;

    // input stage
    logic                 in_valid_reg;
    logic [OP_W-1:0]      op_reg;
    logic [DATA_W-1:0]    data_reg;
    logic                 ren_reg;
    logic                 line_reg;

    // scroll state
    addr_t                temp_addr_reg,  temp_addr_next;
    addr_t                current_addr_reg, current_addr_next;
    logic [FINE_X_W-1:0]  fine_x_reg, fine_x_next;
    logic                 toggle_reg, toggle_next;
    logic                 inc32_reg, inc32_next;

    // result stage
    logic                         out_valid_reg;
    logic [OUT_TDATA_W-1:0]       out_data_reg;
    logic [OUT_TDATA_W-1:0]       out_data_next;

    logic advance;
    logic s_accept;

    // the input stage moves on when the result register is free or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg   <= s_axis_tdata[3:0];
            data_reg <= s_axis_tdata[11:4];
            ren_reg  <= s_axis_tdata[12];
            line_reg <= s_axis_tdata[13];
        end
    end

    // state update for the operation in the input stage
    always_comb begin
        temp_addr_next    = temp_addr_reg;
        current_addr_next = current_addr_reg;
        fine_x_next       = fine_x_reg;
        toggle_next       = toggle_reg;
        inc32_next        = inc32_reg;

        unique case (op_reg)
            OP_CTRL_WRITE: begin
                temp_addr_next[11:10] = data_reg[1:0];
                inc32_next            = data_reg[2];
            end
            OP_SCROLL_WRITE: begin
                if (!toggle_reg) begin
                    temp_addr_next[4:0] = data_reg[7:3];
                    fine_x_next         = data_reg[2:0];
                    toggle_next         = 1'b1;
                end else begin
                    temp_addr_next[14:12] = data_reg[2:0];
                    temp_addr_next[9:5]   = data_reg[7:3];
                    toggle_next           = 1'b0;
                end
            end
            OP_ADDR_WRITE: begin
                if (!toggle_reg) begin
                    // high byte, bit 14 cleared
                    temp_addr_next[14]   = 1'b0;
                    temp_addr_next[13:8] = data_reg[5:0];
                    toggle_next          = 1'b1;
                end else begin
                    temp_addr_next[7:0] = data_reg;
                    current_addr_next   = {temp_addr_reg[14:8], data_reg};
                    toggle_next         = 1'b0;
                end
            end
            OP_STATUS_READ: begin
                toggle_next = 1'b0;
            end
            OP_DATA_ACCESS: begin
                if (ren_reg && line_reg) begin
                    current_addr_next = coarse_step_x(coarse_step_y(current_addr_reg));
                end else if (inc32_reg) begin
                    current_addr_next = current_addr_reg + addr_t'(32);
                end else begin
                    current_addr_next = current_addr_reg + addr_t'(1);
                end
            end
            OP_HINC: begin
                if (ren_reg) begin
                    current_addr_next = coarse_step_x(current_addr_reg);
                end
            end
            OP_VINC: begin
                if (ren_reg) begin
                    current_addr_next = coarse_step_y(current_addr_reg);
                end
            end
            OP_HTRANSFER: begin
                if (ren_reg) begin
                    current_addr_next = (current_addr_reg & ~HORIZ_MASK)
                                      | (temp_addr_reg & HORIZ_MASK);
                end
            end
            OP_VTRANSFER: begin
                if (ren_reg) begin
                    current_addr_next = (current_addr_reg & ~VERT_MASK)
                                      | (temp_addr_reg & VERT_MASK);
                end
            end
            default: begin
                // unused codes leave the state alone
            end
        endcase
    end

    // result fields from the updated address
    always_comb begin
        logic [FETCH_W-1:0] nt_addr;
        logic [FETCH_W-1:0] at_addr;
        logic [SHIFT_W-1:0] at_shift;
        nt_addr  = {2'b10, current_addr_next[11:0]};
        at_addr  = {2'b10, current_addr_next[11:10], 4'b1111,
                    current_addr_next[9:7], current_addr_next[4:2]};
        at_shift = {current_addr_next[6], current_addr_next[1], 1'b0};
        out_data_next = {6'd0, at_shift, at_addr, nt_addr, toggle_next,
                         fine_x_next, current_addr_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_addr_reg    <= '0;
            current_addr_reg <= '0;
            fine_x_reg       <= '0;
            toggle_reg       <= 1'b0;
            inc32_reg        <= 1'b0;
        end else if (advance) begin
            temp_addr_reg    <= temp_addr_next;
            current_addr_reg <= current_addr_next;
            fine_x_reg       <= fine_x_next;
            toggle_reg       <= toggle_next;
            inc32_reg        <= inc32_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
